// File: rtl/core/lsp_pkg.sv
// Shared types and constants for the looping sample player.
package lsp_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PLAY = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_START_FRAME    = 3'd0;
    localparam logic [2:0] CFG_END_FRAME      = 3'd1;
    localparam logic [2:0] CFG_DATA_FRAMES    = 3'd2;
    localparam logic [2:0] CFG_LOOP_ENABLE    = 3'd3;
    localparam logic [2:0] CFG_GAIN           = 3'd4;
    localparam logic [2:0] CFG_AUDIO_CHANNELS = 3'd5;
    localparam logic [2:0] CFG_OUT_CHANNELS   = 3'd6;

    // Register reset values
    localparam logic [15:0] GAIN_UNITY    = 16'd4096;
    localparam logic [3:0]  AUDIO_CH_INIT = 4'd1;
    localparam logic [3:0]  OUT_CH_INIT   = 4'd2;

    // Fixed field widths
    localparam int POS_W    = 13;
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int ROUND_SH = 12;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(2048);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_OUT
    } state_t;

    // Control from the sequencer to the sample path
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic mul_en;
        logic silent;
    } path_ctrl_t;

endpackage

// File: rtl/core/looping_sample_player.sv
// Looping sample player: one voice playing a multichannel clip from memory.
// Play, stop and load words are accepted while idle. A tick word is accepted, a read
// state fetches the first sample, then each output channel passes a multiply state and
// an output state, which waits for a free output slot and reads the next channel's
// sample through the single memory read port; no word is taken until the tick ends.
// aresetn (synchronous, active low) clears control registers, not frame, payload or memory.
module looping_sample_player #(
    parameter int MAX_FRAMES        = 4096,
    parameter int MAX_CLIP_CHANNELS = 8,
    parameter int MAX_OUT_CHANNELS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // load_channel[2:0], load_frame[14:3], load_sample[30:15]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // sample[15:0], position[28:16]
    output logic [3:0]  m_tuser,  // out_channel[2:0], is_playing[3]
    output logic        m_tlast
);

    localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW  = (MAX_CLIP_CHANNELS > 1) ? $clog2(MAX_CLIP_CHANNELS) : 1;
    localparam int AW  = CW + FW;
    localparam int DEPTH = MAX_CLIP_CHANNELS * (2 ** FW);
    localparam int OUT_LIMIT = (MAX_OUT_CHANNELS < 8) ? MAX_OUT_CHANNELS : 8;
    localparam int P = lsp_pkg::POS_W;

    // Configuration registers
    logic [P-1:0]  start_frame_reg;
    logic [P-1:0]  end_frame_reg;
    logic [P-1:0]  data_frames_reg;
    logic          loop_enable_reg;
    logic [15:0]   gain_reg;
    logic [3:0]    audio_channels_reg;
    logic [3:0]    out_channels_reg;

    // Voice state and tick context
    lsp_pkg::state_t state_reg, state_next;
    logic [P-1:0]  pos_reg, pos_next;
    logic          playing_reg, playing_next;
    logic          sound_reg, sound_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic [2:0]    chan_reg;
    logic [2:0]    last_idx_reg, last_idx_next;
    logic [CW-1:0] src_reg;
    logic [CW-1:0] src_last_reg, src_last_next;
    logic [CW-1:0] src_inc;

    // Output register
    logic          m_valid_reg;
    logic [15:0]   m_sample_reg;
    logic [P-1:0]  m_pos_reg;
    logic [2:0]    m_chan_reg;
    logic          m_last_reg;
    logic          m_play_reg;

    // Input word fields
    logic [1:0]    in_op;
    logic [2:0]    in_ch;
    logic [11:0]   in_fr;
    logic [15:0]   in_smp;
    logic          s_accept;
    logic          out_free;
    logic          out_load;
    logic          chan_is_last;
    logic          load_ok;
    logic [4:0]    ac_clamped;
    logic [3:0]    oc_clamped;
    logic [31:0]   data_end;
    logic [P-1:0]  tick_pos;
    logic          tick_halt;

    lsp_pkg::path_ctrl_t ctrl;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] rd_src;
    logic signed [15:0] scaled;

    assign in_op   = s_tuser;
    assign in_ch   = s_tdata[2:0];
    assign in_fr   = s_tdata[14:3];
    assign in_smp  = s_tdata[30:15];
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign chan_is_last = (chan_reg == last_idx_reg);
    assign src_inc = (src_reg == src_last_reg) ? '0 : CW'(src_reg + 1'b1);

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_frame_reg    <= '0;
            end_frame_reg      <= '0;
            data_frames_reg    <= '0;
            loop_enable_reg    <= 1'b0;
            gain_reg           <= lsp_pkg::GAIN_UNITY;
            audio_channels_reg <= lsp_pkg::AUDIO_CH_INIT;
            out_channels_reg   <= lsp_pkg::OUT_CH_INIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lsp_pkg::CFG_START_FRAME:    start_frame_reg    <= cfg_data[P-1:0];
                lsp_pkg::CFG_END_FRAME:      end_frame_reg      <= cfg_data[P-1:0];
                lsp_pkg::CFG_DATA_FRAMES:    data_frames_reg    <= cfg_data[P-1:0];
                lsp_pkg::CFG_LOOP_ENABLE:    loop_enable_reg    <= cfg_data[0];
                lsp_pkg::CFG_GAIN:           gain_reg           <= cfg_data;
                lsp_pkg::CFG_AUDIO_CHANNELS: audio_channels_reg <= cfg_data[3:0];
                lsp_pkg::CFG_OUT_CHANNELS:   out_channels_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Clamp channel counts and the data end
    always_comb begin
        if (audio_channels_reg == 4'd0) begin
            ac_clamped = 5'd1;
        end else if (32'(audio_channels_reg) > MAX_CLIP_CHANNELS) begin
            ac_clamped = 5'(MAX_CLIP_CHANNELS);
        end else begin
            ac_clamped = {1'b0, audio_channels_reg};
        end
        if (out_channels_reg == 4'd0) begin
            oc_clamped = 4'd1;
        end else if (32'(out_channels_reg) > OUT_LIMIT) begin
            oc_clamped = 4'(OUT_LIMIT);
        end else begin
            oc_clamped = out_channels_reg;
        end
        if (32'(data_frames_reg) > MAX_FRAMES) begin
            data_end = 32'(MAX_FRAMES);
        end else begin
            data_end = 32'(data_frames_reg);
        end
    end

    // Work out the voice update for the accepted word
    always_comb begin
        pos_next      = pos_reg;
        playing_next  = playing_reg;
        sound_next    = sound_reg;
        frame_next    = frame_reg;
        last_idx_next = last_idx_reg;
        src_last_next = src_last_reg;
        tick_pos      = pos_reg;
        tick_halt     = 1'b0;
        load_ok       = (32'(in_ch) < MAX_CLIP_CHANNELS) && (32'(in_fr) < MAX_FRAMES);
        if (s_accept) begin
            case (in_op)
                lsp_pkg::OP_PLAY: begin
                    if (data_frames_reg != '0) begin
                        playing_next = 1'b1;
                        pos_next     = start_frame_reg;
                    end
                end
                lsp_pkg::OP_STOP: begin
                    playing_next = 1'b0;
                end
                lsp_pkg::OP_LOAD: begin
                    playing_next = 1'b0;
                    pos_next     = '0;
                end
                default: begin
                    // Tick: wrap or halt at the end frame, play if inside the data
                    sound_next    = 1'b0;
                    last_idx_next = 3'(oc_clamped - 4'd1);
                    src_last_next = CW'(ac_clamped - 5'd1);
                    if (playing_reg && data_frames_reg != '0) begin
                        if (pos_reg >= end_frame_reg) begin
                            tick_pos = start_frame_reg;
                            if (!loop_enable_reg) begin
                                playing_next = 1'b0;
                                tick_halt    = 1'b1;
                            end
                        end
                        if (!tick_halt && 32'(tick_pos) < data_end) begin
                            sound_next = 1'b1;
                            frame_next = FW'(32'(tick_pos));
                            pos_next   = P'(tick_pos + 1'b1);
                        end else begin
                            pos_next   = tick_pos;
                        end
                    end
                end
            endcase
        end
    end

    // Hold voice state and tick context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            playing_reg  <= 1'b0;
            sound_reg    <= 1'b0;
            last_idx_reg <= '0;
            src_last_reg <= '0;
        end else begin
            pos_reg      <= pos_next;
            playing_reg  <= playing_next;
            sound_reg    <= sound_next;
            last_idx_reg <= last_idx_next;
            src_last_reg <= src_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsp_pkg::ST_IDLE: begin
                if (s_accept && in_op == lsp_pkg::OP_TICK) begin
                    state_next = lsp_pkg::ST_READ;
                end
            end
            lsp_pkg::ST_READ: state_next = lsp_pkg::ST_MUL;
            lsp_pkg::ST_MUL:  state_next = lsp_pkg::ST_OUT;
            lsp_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = chan_is_last ? lsp_pkg::ST_IDLE : lsp_pkg::ST_MUL;
                end
            end
            default: state_next = lsp_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_tready    = 1'b0;
        ctrl.wr_en  = 1'b0;
        ctrl.rd_en  = 1'b0;
        ctrl.mul_en = 1'b0;
        ctrl.silent = !sound_reg;
        out_load    = 1'b0;
        rd_src      = src_reg;
        unique case (state_reg)
            lsp_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                ctrl.wr_en = s_accept && in_op == lsp_pkg::OP_LOAD && load_ok;
            end
            lsp_pkg::ST_READ: begin
                ctrl.rd_en = sound_reg;
            end
            lsp_pkg::ST_MUL: begin
                ctrl.mul_en = 1'b1;
            end
            lsp_pkg::ST_OUT: begin
                out_load   = out_free;
                ctrl.rd_en = out_free && !chan_is_last && sound_reg;
                rd_src     = src_inc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance output and clip channel counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= '0;
            src_reg  <= '0;
        end else if (state_reg == lsp_pkg::ST_IDLE) begin
            chan_reg <= '0;
            src_reg  <= '0;
        end else if (out_load) begin
            chan_reg <= 3'(chan_reg + 1'b1);
            src_reg  <= src_inc;
        end
    end

    // Memory addresses
    assign wr_addr = AW'((32'(in_ch) << FW) | 32'(in_fr));
    assign rd_addr = {rd_src, frame_reg};

    lsp_sample_path #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_path (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .wr_addr (wr_addr),
        .wr_data (in_smp),
        .rd_addr (rd_addr),
        .gain    (gain_reg),
        .scaled  (scaled)
    );

    // Output register: valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sample_reg <= scaled;
            m_pos_reg    <= pos_reg;
            m_chan_reg   <= chan_reg;
            m_last_reg   <= chan_is_last;
            m_play_reg   <= playing_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_pos_reg, m_sample_reg};
    assign m_tuser  = {m_play_reg, m_chan_reg};
    assign m_tlast  = m_last_reg;

    // Checks
    a_tick_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_op == lsp_pkg::OP_TICK) |=> state_reg == lsp_pkg::ST_READ)
        else $error("tick did not start a read");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("output word overwritten while held");

    a_last_ends_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && chan_is_last) |=> state_reg == lsp_pkg::ST_IDLE)
        else $error("tick did not finish after last channel");

    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.wr_en |-> (state_reg == lsp_pkg::ST_IDLE && !ctrl.rd_en))
        else $error("memory written during a tick");

endmodule

// File: rtl/core/lsp_sample_path.sv
// Sample memory, gain multiplier and rounding/saturation of one output word.
module lsp_sample_path #(
    parameter int AW    = 15,
    parameter int DEPTH = 32768
) (
    input  logic                               aclk,
    input  lsp_pkg::path_ctrl_t                ctrl,
    input  logic [AW-1:0]                      wr_addr,
    input  logic signed [lsp_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [AW-1:0]                      rd_addr,
    input  logic [lsp_pkg::GAIN_W-1:0]         gain,
    output logic signed [lsp_pkg::SAMPLE_W-1:0] scaled
);

    logic signed [lsp_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic signed [lsp_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic signed [lsp_pkg::PROD_W-1:0]   prod_reg;
    logic signed [lsp_pkg::PROD_W-1:0]   prod_next;
    logic signed [lsp_pkg::PROD_W:0]     rounded;
    logic signed [lsp_pkg::PROD_W-lsp_pkg::ROUND_SH:0] shifted;

    // Write one sample on a load word
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one sample, registered
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Multiply by the Q4.12 gain; force zero for silence
    always_comb begin
        if (ctrl.silent) begin
            prod_next = '0;
        end else begin
            prod_next = rd_data_reg * $signed({1'b0, gain});
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // Round half up with floor shift, then saturate to 16 bits
    always_comb begin
        rounded = {prod_reg[lsp_pkg::PROD_W-1], prod_reg} + $signed(lsp_pkg::ROUND_HALF);
        shifted = rounded[lsp_pkg::PROD_W:lsp_pkg::ROUND_SH];
        if (shifted > $signed((lsp_pkg::PROD_W - lsp_pkg::ROUND_SH + 1)'(32767))) begin
            scaled = 16'sh7fff;
        end else if (shifted < -$signed((lsp_pkg::PROD_W - lsp_pkg::ROUND_SH + 1)'(32768))) begin
            scaled = -16'sh8000;
        end else begin
            scaled = shifted[lsp_pkg::SAMPLE_W-1:0];
        end
    end

endmodule
